// ===== design/fcam_pkg.sv =====
// Package: formats, constants, types and helpers for the fly camera core.
package fcam_pkg;

  localparam int ANG_W = 20;
  localparam int TRIG_W = 16;
  localparam int POS_W = 32;
  localparam int SPEED_W = 16;
  localparam int GAIN_W = 20;
  localparam int DELTA_W = 11;
  localparam int FTIME_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_GAIN = 1'd1;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd768;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd33554;

  localparam logic signed [23:0] FIX_TWO_PI = 24'sd411775;
  localparam logic signed [23:0] FIX_PI = 24'sd205887;
  localparam logic signed [23:0] FIX_HALF_PI = 24'sd102944;
  localparam logic signed [23:0] PITCH_CLAMP = 24'sd101797;
  localparam logic signed [23:0] ANG_MAX = 24'sd524287;
  localparam logic signed [23:0] ANG_MIN = -24'sd524288;
  localparam logic signed [27:0] CORDIC_GAIN = 28'sd10188014;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [POS_W-1:0] EYE_Y_RESET = 32'sd131072;
  localparam logic signed [POS_W-1:0] EYE_Z_RESET = 32'sd524288;

  // CORDIC arctangent table, Q.24
  function automatic logic signed [27:0] atan_q24(input logic [3:0] i);
    case (i)
      4'd0: atan_q24 = 28'sd13176795;
      4'd1: atan_q24 = 28'sd7778716;
      4'd2: atan_q24 = 28'sd4110060;
      4'd3: atan_q24 = 28'sd2086331;
      4'd4: atan_q24 = 28'sd1047214;
      4'd5: atan_q24 = 28'sd524117;
      4'd6: atan_q24 = 28'sd262123;
      4'd7: atan_q24 = 28'sd131069;
      4'd8: atan_q24 = 28'sd65536;
      4'd9: atan_q24 = 28'sd32768;
      4'd10: atan_q24 = 28'sd16384;
      4'd11: atan_q24 = 28'sd8192;
      4'd12: atan_q24 = 28'sd4096;
      4'd13: atan_q24 = 28'sd2048;
      4'd14: atan_q24 = 28'sd1024;
      default: atan_q24 = 28'sd512;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[POS_W-1:0];
  endfunction

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;   // latch item and step
  localparam logic [3:0] OP_FWDX = 4'd2;
  localparam logic [3:0] OP_FWDZ = 4'd3;
  localparam logic [3:0] OP_MOVE = 4'd4;   // one axis of one key move
  localparam logic [3:0] OP_ANGLE = 4'd5;
  localparam logic [3:0] OP_CINIT = 4'd6;
  localparam logic [3:0] OP_CITER = 4'd7;
  localparam logic [3:0] OP_CDONE = 4'd8;
  localparam logic [3:0] OP_MAT = 4'd9;    // one matrix slot: product or dot step
  localparam logic [3:0] OP_OUT = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] key;    // forward, back, right, left
    logic [1:0] axis;   // x, y, z
    logic       sel;    // 0 yaw, 1 pitch
    logic [3:0] idx;    // cordic step or matrix slot
  } fcam_cmd_t;

  typedef struct packed {
    logic [3:0] keys;   // forward, back, right, left
    logic       shift;
  } fcam_status_t;

endpackage

// ===== design/fcam_if.sv =====
// Interfaces: valid/ready channels for input items, results and configuration.
interface fcam_in_if;
  logic valid;
  logic ready;
  logic key_forward;
  logic key_back;
  logic key_right;
  logic key_left;
  logic shift_held;
  logic signed [10:0] look_dx;
  logic signed [10:0] look_dy;
  logic [15:0] frame_time;
  modport source (output valid, key_forward, key_back, key_right, key_left, shift_held,
                  look_dx, look_dy, frame_time, input ready);
  modport sink (input valid, key_forward, key_back, key_right, key_left, shift_held,
                look_dx, look_dy, frame_time, output ready);
endinterface

interface fcam_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] right_x;
  logic signed [15:0] right_z;
  logic signed [31:0] right_offset;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [31:0] up_offset;
  logic signed [15:0] back_x;
  logic signed [15:0] back_y;
  logic signed [15:0] back_z;
  logic signed [31:0] back_offset;
  modport source (output valid, right_x, right_z, right_offset, up_x, up_y, up_z,
                  up_offset, back_x, back_y, back_z, back_offset, input ready);
  modport sink (input valid, right_x, right_z, right_offset, up_x, up_y, up_z,
                up_offset, back_x, back_y, back_z, back_offset, output ready);
endinterface

interface fcam_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/fly_camera_pose_and_view_matrix_core.sv =====
// Top level: fly camera pose update and view matrix core.
//  channel | dir | handshake      | beat
//  in_     | in  | valid/ready    | keys, mouse deltas, frame time
//  out_    | out | valid/ready    | 11 view matrix entries
//  cfg_    | in  | valid/ready    | register index, write data
// One item runs load, 2 forward products, 12 move slots, angle update,
// two CORDIC passes (yaw, then pitch), 13 matrix slots and result load.
// The CORDIC iterations dominate the latency.
// Reset (rst_n low, synchronous) restores registers and camera pose.
// A new beat is taken only once the previous result has been taken.
module fly_camera_pose_and_view_matrix_core
  import fcam_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  fcam_in_if.sink    in_ch,
  fcam_out_if.source out_ch,
  fcam_cfg_if.sink   cfg_ch
);

  fcam_cmd_t    cmd;
  fcam_status_t status;

  fcam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  fcam_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (cmd.op == OP_LOAD)) else $error("load missing");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready after accept");
`endif

endmodule

// ===== design/fcam_ctrl.sv =====
// Controller: sequences movement, angle update, CORDIC and matrix products.
module fcam_ctrl
  import fcam_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_valid,
  input  fcam_status_t status,
  output fcam_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FWD = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_ANG = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_MAT = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] key_r, key_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // result register frees when the previous result is taken
  assign in_ready = (state_r == S_IDLE) && !out_valid;

  always_comb begin
    state_nxt = state_r;
    key_nxt = key_r;
    axis_nxt = axis_r;
    sel_nxt = sel_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.key = key_r;
    cmd.axis = axis_r;
    cmd.sel = sel_r;
    cmd.idx = cnt_r[3:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = OP_LOAD;
          state_nxt = S_FWD;
          cnt_nxt = '0;
        end
      end
      S_FWD: begin
        cmd.op = cnt_r[0] ? OP_FWDZ : OP_FWDX;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[0]) begin
          key_nxt = '0;
          axis_nxt = '0;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.op = (status.keys[key_r] && !status.shift) ? OP_MOVE : OP_NONE;
        if (axis_r == 2'd2) begin
          axis_nxt = '0;
          key_nxt = key_r + 2'd1;
          if (key_r == 2'd3) state_nxt = S_ANG;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_ANG: begin
        cmd.op = OP_ANGLE;
        sel_nxt = 1'b0;
        cnt_nxt = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        // cnt 0: init, 1..16: iterations, 17: finish
        if (cnt_r == 5'd0) cmd.op = OP_CINIT;
        else if (cnt_r == 5'd17) cmd.op = OP_CDONE;
        else begin
          cmd.op = OP_CITER;
          cmd.idx = 4'(cnt_r - 5'd1);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd17) begin
          cnt_nxt = '0;
          if (sel_r) state_nxt = S_MAT;
          else sel_nxt = 1'b1;
        end
      end
      S_MAT: begin
        cmd.op = OP_MAT;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd12) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_r <= '0;
      axis_r <= '0;
      sel_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      key_r <= key_nxt;
      axis_r <= axis_nxt;
      sel_r <= sel_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/fcam_datapath.sv =====
// Datapath: pose state, shared movement multiplier, CORDIC unit and result register.
module fcam_datapath
  import fcam_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fcam_in_if.sink       in_ch,
  fcam_out_if.source    out_ch,
  fcam_cfg_if.sink      cfg_ch,
  input  fcam_cmd_t     cmd,
  output fcam_status_t  status
);

  logic [SPEED_W-1:0] speed_r;
  logic [GAIN_W-1:0]  gain_r;
  logic signed [ANG_W-1:0] yaw_r, pitch_r;
  logic signed [TRIG_W-1:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [POS_W-1:0] ex_r, ey_r, ez_r;

  fcam_status_t st_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic [31:0] step_r;
  logic signed [TRIG_W-1:0] fx_r, fz_r;

  logic signed [27:0] cx_r, cyv_r, cz_r;
  logic flip_r;

  logic signed [TRIG_W-1:0] m_r [0:3];   // up_x, up_z, back_x, back_z products
  logic signed [63:0] acc_r;

  logic out_valid_r;
  logic signed [TRIG_W-1:0] o_rx_r, o_rz_r, o_ux_r, o_uy_r, o_uz_r, o_bx_r, o_by_r, o_bz_r;
  logic signed [POS_W-1:0] o_ro_r, o_uo_r, o_bo_r;

  assign cfg_ch.ready = 1'b1;
  assign status = st_r;

  // ---- rounding helpers
  function automatic logic signed [TRIG_W-1:0] tmul(input logic signed [TRIG_W-1:0] a,
                                                   input logic signed [TRIG_W-1:0] b);
    logic signed [31:0] p;
    p = (32'(a) * 32'(b)) + 32'sd8192;
    tmul = TRIG_W'(p >>> 14);
  endfunction

  // ---- movement: one 16x32 multiply shared by all keys and axes
  logic signed [TRIG_W-1:0] comp;
  logic signed [49:0] mprod;
  logic signed [POS_W-1:0] disp;
  logic signed [POS_W-1:0] cur;
  logic signed [33:0] moved;

  always_comb begin
    if (cmd.key[1]) begin
      case (cmd.axis)
        2'd0: comp = cy_r;
        2'd1: comp = '0;
        default: comp = sy_r;
      endcase
    end else begin
      case (cmd.axis)
        2'd0: comp = fx_r;
        2'd1: comp = sp_r;
        default: comp = fz_r;
      endcase
    end
    case (cmd.axis)
      2'd0: cur = ex_r;
      2'd1: cur = ey_r;
      default: cur = ez_r;
    endcase
    mprod = 50'(comp) * $signed({18'd0, step_r});
    disp = POS_W'((mprod + 50'sd2097152) >>> 22);
    if (cmd.key[0]) moved = 34'(cur) - 34'(disp);
    else moved = 34'(cur) + 34'(disp);
  end

  // ---- angle update
  logic signed [31:0] dprod_x, dprod_y;
  logic signed [23:0] ya, pa;
  logic signed [23:0] ya1, ya2;

  always_comb begin
    dprod_x = 32'(dx_r) * $signed({12'd0, gain_r});
    dprod_y = 32'(dy_r) * $signed({12'd0, gain_r});
    ya = 24'(yaw_r) + 24'((dprod_x + 32'sd128) >>> 8);
    pa = 24'(pitch_r) + 24'((dprod_y + 32'sd128) >>> 8);
    ya1 = (ya < 0) ? ya + FIX_TWO_PI : ya;
    ya2 = (ya1 > FIX_TWO_PI) ? ya1 - FIX_TWO_PI : ya1;
  end

  // ---- CORDIC reduction
  logic signed [23:0] a0, a1, a2, a3;
  logic fl;
  always_comb begin
    a0 = cmd.sel ? 24'(pitch_r) : 24'(yaw_r);
    a1 = (a0 > FIX_PI) ? a0 - FIX_TWO_PI : a0;
    a2 = (a1 < -FIX_PI) ? a1 + FIX_TWO_PI : a1;
    fl = 1'b0;
    a3 = a2;
    if (a2 > FIX_HALF_PI) begin
      a3 = a2 - FIX_PI;
      fl = 1'b1;
    end else if (a2 < -FIX_HALF_PI) begin
      a3 = a2 + FIX_PI;
      fl = 1'b1;
    end
  end

  logic signed [27:0] xs, ys;
  logic signed [27:0] xr, yr;
  logic signed [TRIG_W-1:0] cres, sres;
  always_comb begin
    xs = cx_r >>> cmd.idx;
    ys = cyv_r >>> cmd.idx;
    xr = (cx_r + 28'sd512) >>> 10;
    yr = (cyv_r + 28'sd512) >>> 10;
    if (flip_r) begin
      xr = -xr;
      yr = -yr;
    end
    if (xr > 28'sd16384) cres = TRIG_ONE;
    else if (xr < -28'sd16384) cres = -TRIG_ONE;
    else cres = TRIG_W'(xr);
    if (yr > 28'sd16384) sres = TRIG_ONE;
    else if (yr < -28'sd16384) sres = -TRIG_ONE;
    else sres = TRIG_W'(yr);
  end

  // ---- matrix: slots 0..3 products, 4..11 dot accumulations
  logic signed [TRIG_W-1:0] ma, mb;
  logic signed [TRIG_W-1:0] mp;
  always_comb begin
    case (cmd.idx)
      4'd0: begin ma = sy_r; mb = sp_r; end
      4'd1: begin ma = cy_r; mb = sp_r; end
      4'd2: begin ma = cp_r; mb = sy_r; end
      4'd3: begin ma = cp_r; mb = cy_r; end
      default: begin ma = sy_r; mb = sp_r; end
    endcase
    mp = tmul(ma, mb);
  end

  logic signed [TRIG_W-1:0] dcoef;
  logic signed [POS_W-1:0] deye;
  logic signed [47:0] dprod;
  always_comb begin
    case (cmd.idx)
      4'd4: begin dcoef = cy_r; deye = ex_r; end
      4'd5: begin dcoef = sy_r; deye = ez_r; end
      4'd6: begin dcoef = m_r[0]; deye = ex_r; end
      4'd7: begin dcoef = cp_r; deye = ey_r; end
      4'd8: begin dcoef = m_r[1]; deye = ez_r; end
      4'd9: begin dcoef = m_r[2]; deye = ex_r; end
      4'd10: begin dcoef = -sp_r; deye = ey_r; end
      4'd11: begin dcoef = m_r[3]; deye = ez_r; end
      default: begin dcoef = '0; deye = '0; end
    endcase
    dprod = 48'(dcoef) * 48'(deye);
  end

  function automatic logic signed [POS_W-1:0] negdot(input logic signed [63:0] s);
    negdot = sat32(-((s + 64'sd8192) >>> 14));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
      gain_r <= GAIN_RESET;
      yaw_r <= '0;
      pitch_r <= '0;
      cy_r <= TRIG_ONE;
      sy_r <= '0;
      cp_r <= TRIG_ONE;
      sp_r <= '0;
      ex_r <= '0;
      ey_r <= EYE_Y_RESET;
      ez_r <= EYE_Z_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_MOVE_SPEED) speed_r <= cfg_ch.data[SPEED_W-1:0];
        else gain_r <= cfg_ch.data;
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          st_r.keys <= {in_ch.key_left, in_ch.key_right, in_ch.key_back, in_ch.key_forward};
          st_r.shift <= in_ch.shift_held;
          dx_r <= in_ch.look_dx;
          dy_r <= in_ch.look_dy;
          step_r <= 32'(speed_r) * 32'(in_ch.frame_time);
        end
        OP_FWDX: fx_r <= tmul(cp_r, sy_r);
        OP_FWDZ: fz_r <= -tmul(cp_r, cy_r);
        OP_MOVE: begin
          case (cmd.axis)
            2'd0: ex_r <= sat32(64'(moved));
            2'd1: ey_r <= sat32(64'(moved));
            default: ez_r <= sat32(64'(moved));
          endcase
        end
        OP_ANGLE: begin
          yaw_r <= (ya2 > ANG_MAX) ? ANG_W'(ANG_MAX) :
                   (ya2 < ANG_MIN) ? ANG_W'(ANG_MIN) : ANG_W'(ya2);
          pitch_r <= (pa > PITCH_CLAMP) ? ANG_W'(PITCH_CLAMP) :
                     (pa < -PITCH_CLAMP) ? ANG_W'(-PITCH_CLAMP) : ANG_W'(pa);
        end
        OP_CINIT: begin
          cx_r <= CORDIC_GAIN;
          cyv_r <= '0;
          cz_r <= 28'(a3) <<< 8;
          flip_r <= fl;
        end
        OP_CITER: begin
          if (!cz_r[27]) begin
            cx_r <= cx_r - ys;
            cyv_r <= cyv_r + xs;
            cz_r <= cz_r - atan_q24(cmd.idx);
          end else begin
            cx_r <= cx_r + ys;
            cyv_r <= cyv_r - xs;
            cz_r <= cz_r + atan_q24(cmd.idx);
          end
        end
        OP_CDONE: begin
          if (cmd.sel) begin
            cp_r <= cres;
            sp_r <= sres;
          end else begin
            cy_r <= cres;
            sy_r <= sres;
          end
        end
        OP_MAT: begin
          case (cmd.idx)
            4'd0: m_r[0] <= -mp;
            4'd1: m_r[1] <= mp;
            4'd2: m_r[2] <= -mp;
            4'd3: m_r[3] <= mp;
            4'd4, 4'd6, 4'd9: acc_r <= 64'(dprod);
            4'd5: begin
              o_ro_r <= negdot(acc_r + 64'(dprod));
            end
            4'd7, 4'd10: acc_r <= acc_r + 64'(dprod);
            4'd8: o_uo_r <= negdot(acc_r + 64'(dprod));
            4'd11: o_bo_r <= negdot(acc_r + 64'(dprod));
            default: ;
          endcase
        end
        OP_OUT: begin
          o_rx_r <= cy_r;
          o_rz_r <= sy_r;
          o_ux_r <= m_r[0];
          o_uy_r <= cp_r;
          o_uz_r <= m_r[1];
          o_bx_r <= m_r[2];
          o_by_r <= -sp_r;
          o_bz_r <= m_r[3];
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.right_x = o_rx_r;
  assign out_ch.right_z = o_rz_r;
  assign out_ch.right_offset = o_ro_r;
  assign out_ch.up_x = o_ux_r;
  assign out_ch.up_y = o_uy_r;
  assign out_ch.up_z = o_uz_r;
  assign out_ch.up_offset = o_uo_r;
  assign out_ch.back_x = o_bx_r;
  assign out_ch.back_y = o_by_r;
  assign out_ch.back_z = o_bz_r;
  assign out_ch.back_offset = o_bo_r;

endmodule

// ===== test/tb_fcam_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts view matrix beats from input and config beats and compares them.
module tb_fcam_checker
  import fcam_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fcam_in_if.sink     in_mon,
  fcam_out_if.sink    out_mon,
  fcam_cfg_if.sink    cfg_mon,
  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    longint rx, rz, roff, ux, uy, uz, uoff, bx, by, bz, boff;
  } view_t;

  view_t pending_views[$];

  longint speed_q, gain_q;
  longint yaw, pitch, cyaw, syaw, cpitch, spitch, ex, ey, ez;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_pos(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint tprod(longint a, longint b);
    return round_shift(a * b, 14);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
    return tbl[i];
  endfunction

  task automatic sin_cos(input longint a, output longint c, output longint s);
    bit flip;
    longint x, y, z, t;
    flip = 0;
    x = 10188014;
    y = 0;
    if (a > 205887) a -= 411775;
    if (a < -205887) a += 411775;
    if (a > 102944) begin
      a -= 205887; flip = 1;
    end else if (a < -102944) begin
      a += 205887; flip = 1;
    end
    z = a * 256;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atan_step(i);
      end else begin
        t = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atan_step(i);
      end
      x = t;
    end
    x = round_shift(x, 10);
    y = round_shift(y, 10);
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -16384, 16384);
    s = clip(y, -16384, 16384);
  endtask

  task automatic shift_eye(longint fx, longint fy, longint fz, longint stp, longint sgn);
    ex = sat_pos(ex + sgn * round_shift(fx * stp, 22));
    ey = sat_pos(ey + sgn * round_shift(fy * stp, 22));
    ez = sat_pos(ez + sgn * round_shift(fz * stp, 22));
  endtask

  function automatic longint eye_offset(longint ax, longint ay, longint az);
    return sat_pos(-round_shift(ax * ex + ay * ey + az * ez, 14));
  endfunction

  task automatic predict_view(input logic [4:0] keys, input longint dx, input longint dy,
                              input longint ft);
    longint stp, fx, fy, fz, ya, pa;
    view_t v;
    stp = speed_q * ft;
    fx = tprod(cpitch, syaw);
    fy = spitch;
    fz = -tprod(cpitch, cyaw);
    if (!keys[4]) begin
      if (keys[0]) shift_eye(fx, fy, fz, stp, 1);
      if (keys[1]) shift_eye(fx, fy, fz, stp, -1);
      if (keys[2]) shift_eye(cyaw, 0, syaw, stp, 1);
      if (keys[3]) shift_eye(cyaw, 0, syaw, stp, -1);
    end
    ya = yaw + round_shift(dx * gain_q, 8);
    pa = pitch + round_shift(dy * gain_q, 8);
    if (ya < 0) ya += 411775;
    if (ya > 411775) ya -= 411775;
    yaw = clip(ya, -524288, 524287);
    pitch = clip(pa, -101797, 101797);
    sin_cos(yaw, cyaw, syaw);
    sin_cos(pitch, cpitch, spitch);
    v.rx = cyaw;
    v.rz = syaw;
    v.roff = eye_offset(cyaw, 0, syaw);
    v.ux = -tprod(syaw, spitch);
    v.uy = cpitch;
    v.uz = tprod(cyaw, spitch);
    v.uoff = eye_offset(v.ux, v.uy, v.uz);
    v.bx = -tprod(cpitch, syaw);
    v.by = -spitch;
    v.bz = tprod(cpitch, cyaw);
    v.boff = eye_offset(v.bx, v.by, v.bz);
    pending_views.push_back(v);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = pending_views.size();

  always @(posedge clk) begin
    view_t e;
    if (!rst_n) begin
      speed_q = 768; gain_q = 33554;
      yaw = 0; pitch = 0;
      cyaw = 16384; syaw = 0; cpitch = 16384; spitch = 0;
      ex = 0; ey = 131072; ez = 524288;
      pending_views.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MOVE_SPEED) speed_q = cfg_mon.data[15:0];
        else if (cfg_mon.index == REG_MOUSE_GAIN) gain_q = cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_views.size() == 0) begin
          $error("view beat with no prediction waiting");
          fail_count++;
        end else begin
          e = pending_views.pop_front();
          check_field("right_x", e.rx, out_mon.right_x);
          check_field("right_z", e.rz, out_mon.right_z);
          check_field("right_offset", e.roff, out_mon.right_offset);
          check_field("up_x", e.ux, out_mon.up_x);
          check_field("up_y", e.uy, out_mon.up_y);
          check_field("up_z", e.uz, out_mon.up_z);
          check_field("up_offset", e.uoff, out_mon.up_offset);
          check_field("back_x", e.bx, out_mon.back_x);
          check_field("back_y", e.by, out_mon.back_y);
          check_field("back_z", e.bz, out_mon.back_z);
          check_field("back_offset", e.boff, out_mon.back_offset);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_view({in_mon.shift_held, in_mon.key_left, in_mon.key_right,
                      in_mon.key_back, in_mon.key_forward},
                     longint'(in_mon.look_dx), longint'(in_mon.look_dy),
                     longint'(in_mon.frame_time));
    end
  end

endmodule

// ===== test/tb_fly_camera_pose_and_view_matrix_core.sv =====
`timescale 1ns / 1ps
// Testbench top: drives frame ticks and config writes, gives the verdict.
module tb_fly_camera_pose_and_view_matrix_core;
  import fcam_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_stall_pct;
  int   hold_cycles;
  int   quiet_cycles;

  fcam_in_if  in_ch();
  fcam_out_if out_ch();
  fcam_cfg_if cfg_ch();

  fly_camera_pose_and_view_matrix_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tb_fcam_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0; in_ch.key_forward = 0; in_ch.key_back = 0; in_ch.key_right = 0;
    in_ch.key_left = 0; in_ch.shift_held = 0; in_ch.look_dx = 0; in_ch.look_dy = 0;
    in_ch.frame_time = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_MOVE_SPEED; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  // receiver: random stalls, plus a long hold when hold_cycles is set
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no beat accepted anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(logic [4:0] keys, logic [10:0] dx, logic [10:0] dy,
                           logic [15:0] ft);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    {in_ch.shift_held, in_ch.key_left, in_ch.key_right, in_ch.key_back,
     in_ch.key_forward} <= keys;
    in_ch.look_dx <= dx;
    in_ch.look_dy <= dy;
    in_ch.frame_time <= ft;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    // the block stays busy with a beat after taking it, so this wait costs no throughput
    @(posedge clk);
  endtask

  task automatic send_random_tick();
    logic [10:0] dx, dy;
    logic [15:0] ft;
    logic [4:0] keys;
    keys = 5'($urandom);
    if ($urandom_range(3) != 0) keys[4] = 1'b0;
    case ($urandom_range(3))
      0: dx = 11'($urandom);
      1: dx = $urandom_range(1) ? 11'h3FF : 11'h400;
      default: dx = 11'($signed($urandom_range(80)) - 40);
    endcase
    dy = ($urandom_range(2) == 0) ? 11'($urandom) : 11'($signed($urandom_range(80)) - 40);
    ft = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(2000));
    send_tick(keys, dx, dy, ft);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [19:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers, extremes and special cases
    send_tick(5'b00000, 11'h000, 11'h000, 16'h0000);
    send_tick(5'b00001, 11'h3FF, 11'h3FF, 16'hFFFF);
    send_tick(5'b00010, 11'h400, 11'h400, 16'hFFFF);
    send_tick(5'b00100, 11'h3FF, 11'h000, 16'h8000);
    send_tick(5'b01000, 11'h400, 11'h3FF, 16'h1234);
    send_tick(5'b00011, 11'h010, 11'h7F0, 16'hFFFF);
    send_tick(5'b01100, 11'h7F0, 11'h010, 16'hFFFF);
    send_tick(5'b11111, 11'h3FF, 11'h400, 16'hFFFF);
    send_tick(5'b10101, 11'h001, 11'h7FF, 16'h0001);
    drain();

    // max speed and gain: large eye moves, large yaw steps
    write_reg(REG_MOVE_SPEED, 20'h0FFFF);
    write_reg(REG_MOUSE_GAIN, 20'hFFFFF);
    repeat (6) send_tick(5'b00001, 11'h3FF, 11'h3FF, 16'hFFFF);
    repeat (4) send_tick(5'b00100, 11'h400, 11'h400, 16'hFFFF);
    repeat (4) send_tick(5'b01010, 11'h3FF, 11'h000, 16'hFFFF);
    drain();
    write_reg(REG_MOVE_SPEED, 20'h00000);
    write_reg(REG_MOUSE_GAIN, 20'h00000);
    send_tick(5'b01111, 11'h3FF, 11'h400, 16'hFFFF);
    drain();

    // random phases across idling patterns and settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MOVE_SPEED, 20'($urandom_range(ph == 5 ? 65535 : 4000)));
      write_reg(REG_MOUSE_GAIN, ph == 4 ? 20'($urandom) : 20'($urandom_range(400000)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (ph == 0) hold_cycles = 600;
      for (int n = 0; n < 105; n++) send_random_tick();
      drain();
    end
    write_reg(REG_MOVE_SPEED, 20'd768);
    write_reg(REG_MOUSE_GAIN, 20'd33554);
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int n = 0; n < 10; n++) send_random_tick();
    drain();

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== fly_camera_pose_and_view_matrix_core.f =====
design/fcam_pkg.sv
design/fcam_if.sv
design/fcam_ctrl.sv
design/fcam_datapath.sv
design/fly_camera_pose_and_view_matrix_core.sv
test/tb_fcam_checker.sv
test/tb_fly_camera_pose_and_view_matrix_core.sv
